// ===== rtl/core/rals_pkg.sv =====
package rals_pkg;

    // pixel geometry
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = 8;
    localparam int CH_IDX_W = 2;
    localparam int DATA_W   = NUM_CH * PIX_W;
    localparam int USER_W   = 2;

    // divider step count: the quotient never exceeds one sample width
    localparam int DIV_STEPS = PIX_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // full-scale output level
    localparam logic [PIX_W-1:0] LEVEL_FULL = 8'd255;

    // tuser bit positions
    localparam int USER_OP  = 0;
    localparam int USER_SOF = 1;

    // operation codes
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_MAP     = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

endpackage

// ===== rtl/core/rgb_auto_level_stretch.sv =====
// observe transaction: statistics updated at the accepting edge, ready again next cycle
// map transaction: a load state per channel, then 8 divide steps unless the sample clamps,
// three channels in turn, then the output register; no new transaction is taken until then,
// and an output stall holds it off, since the 8-step divider is shared; reset (i_rst_n low,
// synchronous): sequencer idle, no result pending, minimum 255 and maximum 0 for every channel
module rgb_auto_level_stretch (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic [rals_pkg::DATA_W-1:0]  s_axis_tdata,
    // operation [0], start_of_frame [1]
    input  logic [rals_pkg::USER_W-1:0]  s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic [rals_pkg::DATA_W-1:0]  m_axis_tdata
);

    localparam int PW = rals_pkg::PIX_W;

    rals_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_min [0:rals_pkg::NUM_CH-1];
    logic [PW-1:0] n_min [0:rals_pkg::NUM_CH-1];
    logic [PW-1:0] r_max [0:rals_pkg::NUM_CH-1];
    logic [PW-1:0] n_max [0:rals_pkg::NUM_CH-1];
    logic [PW-1:0] r_px  [0:rals_pkg::NUM_CH-1];
    logic [PW-1:0] n_px  [0:rals_pkg::NUM_CH-1];
    logic [PW-1:0] r_res [0:rals_pkg::NUM_CH-1];
    logic [PW-1:0] n_res [0:rals_pkg::NUM_CH-1];

    logic [rals_pkg::CH_IDX_W-1:0] r_ch, n_ch;
    logic [rals_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [PW-1:0]                 r_rem, n_rem;
    logic [PW-1:0]                 r_range, n_range;
    logic [PW-1:0]                 r_quo, n_quo;
    logic                          r_m_valid, n_m_valid;
    logic [rals_pkg::DATA_W-1:0]   r_m_data, n_m_data;

    logic          s_acc;
    logic [PW-1:0] sel_v, sel_lo, sel_hi, diff;
    logic [2*PW-1:0] num;
    logic [PW:0]   trial;
    logic          qbit;
    logic          last_ch;

    assign s_axis_tready = (r_state == rals_pkg::ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // operand selection for the channel in work
    assign sel_v   = r_px[r_ch];
    assign sel_lo  = r_min[r_ch];
    assign sel_hi  = r_max[r_ch];
    assign diff    = sel_v - sel_lo;
    // (v - min) * 255 as (d << 8) - d
    assign num     = {diff, {PW{1'b0}}} - {{PW{1'b0}}, diff};
    assign last_ch = (r_ch == rals_pkg::CH_IDX_W'(rals_pkg::NUM_CH - 1));

    // shared restoring divide step
    assign trial = {r_rem, r_quo[PW-1]} - {1'b0, r_range};
    assign qbit  = !trial[PW];

    // sequencer and datapath next state
    always_comb begin
        n_state   = r_state;
        n_min     = r_min;
        n_max     = r_max;
        n_px      = r_px;
        n_res     = r_res;
        n_ch      = r_ch;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_range   = r_range;
        n_quo     = r_quo;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;

        // output register drains on its transaction
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            rals_pkg::ST_IDLE: begin
                if (s_acc) begin
                    for (int c = 0; c < rals_pkg::NUM_CH; c++) begin
                        n_px[c] = s_axis_tdata[c*PW +: PW];
                    end
                    if (s_axis_tuser[rals_pkg::USER_OP] == rals_pkg::OP_MAP) begin
                        n_ch    = '0;
                        n_state = rals_pkg::ST_LOAD;
                    end else begin
                        // statistics update, all channels at once
                        for (int c = 0; c < rals_pkg::NUM_CH; c++) begin
                            if (s_axis_tuser[rals_pkg::USER_SOF]) begin
                                n_min[c] = s_axis_tdata[c*PW +: PW];
                                n_max[c] = s_axis_tdata[c*PW +: PW];
                            end else begin
                                if (s_axis_tdata[c*PW +: PW] < r_min[c]) begin
                                    n_min[c] = s_axis_tdata[c*PW +: PW];
                                end
                                if (s_axis_tdata[c*PW +: PW] > r_max[c]) begin
                                    n_max[c] = s_axis_tdata[c*PW +: PW];
                                end
                            end
                        end
                    end
                end
            end
            rals_pkg::ST_LOAD: begin
                // empty range or sample at or below minimum gives zero
                if (sel_hi <= sel_lo || sel_v <= sel_lo) begin
                    n_res[r_ch] = '0;
                    n_ch        = r_ch + 1'b1;
                    n_state     = last_ch ? rals_pkg::ST_OUT : rals_pkg::ST_LOAD;
                end else if (sel_v >= sel_hi) begin
                    n_res[r_ch] = rals_pkg::LEVEL_FULL;
                    n_ch        = r_ch + 1'b1;
                    n_state     = last_ch ? rals_pkg::ST_OUT : rals_pkg::ST_LOAD;
                end else begin
                    // upper byte is already below the range, so 8 steps suffice
                    n_rem   = num[2*PW-1:PW];
                    n_quo   = num[PW-1:0];
                    n_range = sel_hi - sel_lo;
                    n_cnt   = '0;
                    n_state = rals_pkg::ST_DIV;
                end
            end
            rals_pkg::ST_DIV: begin
                n_rem = qbit ? trial[PW-1:0] : {r_rem[PW-2:0], r_quo[PW-1]};
                n_quo = {r_quo[PW-2:0], qbit};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rals_pkg::CNT_W'(rals_pkg::DIV_STEPS - 1)) begin
                    n_res[r_ch] = {r_quo[PW-2:0], qbit};
                    n_ch        = r_ch + 1'b1;
                    n_state     = last_ch ? rals_pkg::ST_OUT : rals_pkg::ST_LOAD;
                end
            end
            rals_pkg::ST_OUT: begin
                // wait for a free output register
                if (!r_m_valid || m_axis_tready) begin
                    for (int c = 0; c < rals_pkg::NUM_CH; c++) begin
                        n_m_data[c*PW +: PW] = r_res[c];
                    end
                    n_m_valid = 1'b1;
                    n_state   = rals_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rals_pkg::ST_IDLE;
            end
        endcase
    end

    // control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rals_pkg::ST_IDLE;
            r_m_valid <= 1'b0;
            r_ch      <= '0;
            r_cnt     <= '0;
            for (int c = 0; c < rals_pkg::NUM_CH; c++) begin
                r_min[c] <= rals_pkg::LEVEL_FULL;
                r_max[c] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_ch      <= n_ch;
            r_cnt     <= n_cnt;
            r_min     <= n_min;
            r_max     <= n_max;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_px     <= n_px;
        r_res    <= n_res;
        r_rem    <= n_rem;
        r_range  <= n_range;
        r_quo    <= n_quo;
        r_m_data <= n_m_data;
    end

    // divider remainder stays below the divisor
    a_rem_below_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rals_pkg::ST_DIV) |-> (r_rem < r_range && r_range != '0))
        else $error("divider remainder not below range");

    // a map transaction starts the channel sequence at red
    a_map_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tuser[rals_pkg::USER_OP] == rals_pkg::OP_MAP)
        |=> (r_state == rals_pkg::ST_LOAD && r_ch == '0))
        else $error("map transaction did not start at first channel");

    // after an observe transaction every channel has minimum at or below maximum
    a_stats_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tuser[rals_pkg::USER_OP] == rals_pkg::OP_OBSERVE)
        |=> (r_min[0] <= r_max[0] && r_min[1] <= r_max[1] && r_min[2] <= r_max[2]))
        else $error("statistics out of order after observe");

    // channel index stays within the pixel while working
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rals_pkg::ST_LOAD || r_state == rals_pkg::ST_DIV)
        |-> (r_ch < rals_pkg::CH_IDX_W'(rals_pkg::NUM_CH)))
        else $error("channel index out of range");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rals_pkg::ST_OUT && r_m_valid && !m_axis_tready)
        |=> (r_state == rals_pkg::ST_OUT))
        else $error("result loaded over pending output");

endmodule

// ===== bench/rgb_auto_level_stretch_tb.sv =====
`default_nettype none

module rgb_auto_level_stretch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one pixel as the sender offers it
    typedef struct packed {
        logic                       op;
        logic                       sof;
        logic [rals_pkg::PIX_W-1:0] red;
        logic [rals_pkg::PIX_W-1:0] green;
        logic [rals_pkg::PIX_W-1:0] blue;
    } t_pixel;

    // one stretched pixel
    typedef struct packed {
        logic [rals_pkg::PIX_W-1:0] red;
        logic [rals_pkg::PIX_W-1:0] green;
        logic [rals_pkg::PIX_W-1:0] blue;
    } t_levels;

    // pacing of the two sides
    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } t_pace;

    localparam int RECV_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 40;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    logic [rals_pkg::DATA_W-1:0]   s_axis_tdata  = '0;
    // operation [0], start_of_frame [1]
    logic [rals_pkg::USER_W-1:0]   s_axis_tuser  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // red_out [7:0], green_out [15:8], blue_out [23:16]
    logic [rals_pkg::DATA_W-1:0]   m_axis_tdata;

    // stimulus and expectations
    t_pixel                        pixel_q [$];
    t_levels                       level_q [$];
    t_pixel                        offered_px;
    logic [rals_pkg::USER_W-1:0]   offered_user;
    t_levels                       want_lv;
    t_levels                       got_lv;
    t_pace                         pace     = PACE_FULL;
    logic                          hold_req = 1'b0;
    logic                          hold_done;
    int                            hold_left;
    bit                            offer_now;
    int                            mismatch_cnt = 0;
    int                            observe_cnt  = 0;
    int                            map_cnt      = 0;

    // per-channel statistics tracked by the predictor
    logic [rals_pkg::PIX_W-1:0]    stat_lo [rals_pkg::NUM_CH];
    logic [rals_pkg::PIX_W-1:0]    stat_hi [rals_pkg::NUM_CH];

    rgb_auto_level_stretch i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #800_000;
        $display("FAILURE");
        $finish;
    end

    // floor((v - lo) * 255 / (hi - lo)) with clamping at both ends
    function automatic logic [rals_pkg::PIX_W-1:0] stretch_sample(
            input logic [rals_pkg::PIX_W-1:0] v,
            input logic [rals_pkg::PIX_W-1:0] lo,
            input logic [rals_pkg::PIX_W-1:0] hi);
        int span;
        int scaled;
        if (hi <= lo || v <= lo) return '0;
        if (v >= hi) return rals_pkg::LEVEL_FULL;
        span   = int'(hi) - int'(lo);
        scaled = (int'(v) - int'(lo)) * 255 / span;
        return scaled[rals_pkg::PIX_W-1:0];
    endfunction

    // apply one accepted pixel to the statistics or queue its stretched value
    task automatic absorb_pixel(input t_pixel px);
        logic [rals_pkg::PIX_W-1:0] smp [rals_pkg::NUM_CH];
        t_levels                    lv;
        smp[0] = px.red;
        smp[1] = px.green;
        smp[2] = px.blue;
        if (px.op == rals_pkg::OP_OBSERVE) begin
            observe_cnt++;
            for (int c = 0; c < rals_pkg::NUM_CH; c++) begin
                if (px.sof) begin
                    stat_lo[c] = smp[c];
                    stat_hi[c] = smp[c];
                end else begin
                    if (smp[c] < stat_lo[c]) stat_lo[c] = smp[c];
                    if (smp[c] > stat_hi[c]) stat_hi[c] = smp[c];
                end
            end
        end else begin
            map_cnt++;
            lv.red   = stretch_sample(smp[0], stat_lo[0], stat_hi[0]);
            lv.green = stretch_sample(smp[1], stat_lo[1], stat_hi[1]);
            lv.blue  = stretch_sample(smp[2], stat_lo[2], stat_hi[2]);
            level_q.push_back(lv);
        end
    endtask

    // driver: offer queued pixels, pacing by the current mode
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) absorb_pixel(offered_px);
            case (pace)
                PACE_SEND_GAPS: offer_now = $urandom_range(99) >= 83;
                PACE_BOTH:      offer_now = $urandom_range(99) >= 26;
                default:        offer_now = 1'b1;
            endcase
            if (pixel_q.size() != 0 && offer_now) begin
                offered_px                      = pixel_q.pop_front();
                offered_user                    = '0;
                offered_user[rals_pkg::USER_OP]  = offered_px.op;
                offered_user[rals_pkg::USER_SOF] = offered_px.sof;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {offered_px.blue, offered_px.green, offered_px.red};
                s_axis_tuser  <= offered_user;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each result transaction and pace the receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_lv = t_levels'(m_axis_tdata);
                if (level_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
                end else begin
                    want_lv = level_q.pop_front();
                    got_lv.red   = m_axis_tdata[rals_pkg::PIX_W-1:0];
                    got_lv.green = m_axis_tdata[2*rals_pkg::PIX_W-1:rals_pkg::PIX_W];
                    got_lv.blue  = m_axis_tdata[3*rals_pkg::PIX_W-1:2*rals_pkg::PIX_W];
                    if (got_lv.red !== want_lv.red) begin
                        mismatch_cnt++;
                        $display("%0t: red_out expected %0d actual %0d",
                                 $realtime, want_lv.red, got_lv.red);
                    end
                    if (got_lv.green !== want_lv.green) begin
                        mismatch_cnt++;
                        $display("%0t: green_out expected %0d actual %0d",
                                 $realtime, want_lv.green, got_lv.green);
                    end
                    if (got_lv.blue !== want_lv.blue) begin
                        mismatch_cnt++;
                        $display("%0t: blue_out expected %0d actual %0d",
                                 $realtime, want_lv.blue, got_lv.blue);
                    end
                end
            end
            // long hold-off, then random stalls by mode
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_left     <= RECV_HOLD_CYCLES;
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                case (pace)
                    PACE_RECV_STALLS: m_axis_tready <= $urandom_range(99) >= 83;
                    PACE_BOTH:        m_axis_tready <= $urandom_range(99) >= 26;
                    default:          m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    task automatic push_px(input logic op, input logic sof,
                           input logic [rals_pkg::PIX_W-1:0] r,
                           input logic [rals_pkg::PIX_W-1:0] g,
                           input logic [rals_pkg::PIX_W-1:0] b);
        t_pixel px;
        px.op    = op;
        px.sof   = sof;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        pixel_q.push_back(px);
    endtask

    // one observe pass and its map pass, with some stray transactions mixed in
    task automatic push_frame_pair(inout int queued);
        logic [rals_pkg::PIX_W-1:0] lo [rals_pkg::NUM_CH];
        logic [rals_pkg::PIX_W-1:0] hi [rals_pkg::NUM_CH];
        logic [rals_pkg::PIX_W-1:0] img [12][rals_pkg::NUM_CH];
        int                         npix;
        int                         k;
        npix = $urandom_range(2, 12);
        for (int c = 0; c < rals_pkg::NUM_CH; c++) begin
            case ($urandom_range(7))
                0, 1: begin
                    lo[c] = 8'd0;
                    hi[c] = 8'd255;
                end
                2: begin
                    lo[c] = rals_pkg::PIX_W'($urandom_range(255));
                    hi[c] = lo[c];
                end
                default: begin
                    lo[c] = rals_pkg::PIX_W'($urandom_range(255));
                    hi[c] = rals_pkg::PIX_W'($urandom_range(lo[c], 255));
                end
            endcase
        end
        for (int p = 0; p < npix; p++)
            for (int c = 0; c < rals_pkg::NUM_CH; c++)
                img[p][c] = rals_pkg::PIX_W'($urandom_range(lo[c], hi[c]));
        // observe pass, start flag on the first pixel
        for (int p = 0; p < npix; p++)
            push_px(rals_pkg::OP_OBSERVE, p == 0, img[p][0], img[p][1], img[p][2]);
        // map pass on randomly picked pixels, some pixels off the frame, some with a stray start flag
        for (int p = 0; p < npix; p++) begin
            k = $urandom_range(npix - 1);
            if ($urandom_range(9) == 0)
                push_px(rals_pkg::OP_MAP, 1'($urandom), rals_pkg::PIX_W'($urandom),
                        rals_pkg::PIX_W'($urandom), rals_pkg::PIX_W'($urandom));
            else
                push_px(rals_pkg::OP_MAP, $urandom_range(9) == 0,
                        img[k][0], img[k][1], img[k][2]);
        end
        queued += 2 * npix;
        // noise: random transactions that break the frame pattern
        if ($urandom_range(9) < 2) begin
            k = $urandom_range(1, 4);
            for (int n = 0; n < k; n++)
                push_px(1'($urandom), 1'($urandom), rals_pkg::PIX_W'($urandom),
                        rals_pkg::PIX_W'($urandom), rals_pkg::PIX_W'($urandom));
            queued += k;
        end
    endtask

    // wait until all queued pixels were taken and every result has come
    task automatic drain;
        while (pixel_q.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (level_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(input t_pace mode, input int n_items);
        int queued;
        queued = 0;
        @(negedge i_clk);
        pace = mode;
        while (queued < n_items) push_frame_pair(queued);
        drain();
    endtask

    // stimulus
    initial begin
        for (int c = 0; c < rals_pkg::NUM_CH; c++) begin
            stat_lo[c] = rals_pkg::LEVEL_FULL;
            stat_hi[c] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: maps with no statistics after reset, one with a start flag
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd0, 8'd128, 8'd255);
        push_px(rals_pkg::OP_MAP, 1'b1, 8'd255, 8'd0, 8'd77);
        // build ranges red 10..200, green 20..100, blue stuck at 30
        push_px(rals_pkg::OP_OBSERVE, 1'b1, 8'd10, 8'd20, 8'd30);
        push_px(rals_pkg::OP_OBSERVE, 1'b0, 8'd200, 8'd100, 8'd30);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd10, 8'd20, 8'd30);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd200, 8'd100, 8'd30);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd0, 8'd0, 8'd0);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd255, 8'd255, 8'd255);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd105, 8'd60, 8'd31);
        // start flag on a map leaves the statistics alone
        push_px(rals_pkg::OP_MAP, 1'b1, 8'd11, 8'd99, 8'd29);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd199, 8'd21, 8'd30);
        // full-scale ranges
        push_px(rals_pkg::OP_OBSERVE, 1'b1, 8'd0, 8'd255, 8'd0);
        push_px(rals_pkg::OP_OBSERVE, 1'b0, 8'd255, 8'd0, 8'd255);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd0, 8'd255, 8'd1);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd1, 8'd128, 8'd254);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd255, 8'd0, 8'd127);
        // a later observe without the start flag keeps widening
        push_px(rals_pkg::OP_OBSERVE, 1'b1, 8'd100, 8'd100, 8'd100);
        push_px(rals_pkg::OP_OBSERVE, 1'b0, 8'd101, 8'd102, 8'd100);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd101, 8'd101, 8'd100);
        push_px(rals_pkg::OP_OBSERVE, 1'b0, 8'd50, 8'd200, 8'd99);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd75, 8'd150, 8'd100);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd49, 8'd201, 8'd98);
        // single-pixel frame gives zero range everywhere
        push_px(rals_pkg::OP_OBSERVE, 1'b1, 8'd170, 8'd85, 8'd42);
        push_px(rals_pkg::OP_MAP, 1'b0, 8'd171, 8'd85, 8'd41);
        drain();

        run_phase(PACE_FULL, 300);
        run_phase(PACE_SEND_GAPS, 300);
        run_phase(PACE_RECV_STALLS, 300);
        run_phase(PACE_BOTH, 300);

        // long receiver hold-off while the sender keeps offering
        @(negedge i_clk);
        pace     = PACE_FULL;
        hold_req = 1'b1;
        run_phase(PACE_FULL, 100);

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("covered %0d observe and %0d map transactions", observe_cnt, map_cnt);
        $display("pacing: free flow, sender gaps, receiver stalls, both, long hold-off");
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
